@@ rtl/core/tcphcb_pkg.sv @@
// ----------------------------------------------------------------------------
// tcphcb_pkg
// Shared types, codes and constants for the TCP header checksum builder.
// ----------------------------------------------------------------------------
package tcphcb_pkg;

   localparam logic CMD_HEADER  = 1'b0;
   localparam logic CMD_PAYLOAD = 1'b1;

   localparam logic CSR_LOCAL_IP    = 1'b0;
   localparam logic CSR_WINDOW_SIZE = 1'b1;

   localparam logic [16:0] MAX_PAYLOAD  = 17'd65515;
   localparam logic [16:0] HDR_BYTES    = 17'd20;
   localparam logic [15:0] PROTO_TCP    = 16'd6;
   localparam logic [15:0] WORD_MASK    = 16'hFFFF;
   localparam logic [15:0] WINDOW_RESET = 16'd8192;
   localparam logic [7:0]  OFFSET_BYTE  = 8'h50;

   typedef struct packed {
      logic [16:0] run_sum;
      logic [15:0] extra;
      logic [19:0] hdr_sum;
      logic [31:0] ports;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [7:0]  flags;
      logic [16:0] count;
   } close_in_type;

   typedef struct packed {
      logic [63:0] header_front;
      logic [63:0] header_middle;
      logic [31:0] header_back;
      logic [15:0] tcp_length;
      logic        status;
   } result_type;

   // sum of the segment-constant header words: destination, ports, seq, ack, offset/flags
   function automatic logic [19:0] hdr_word_sum(input logic [31:0] dest_ip,
                                                input logic [31:0] ports,
                                                input logic [31:0] seq,
                                                input logic [31:0] ack,
                                                input logic [7:0]  flags);
      hdr_word_sum = 20'(dest_ip[31:16]) + 20'(dest_ip[15:0])
                   + 20'(ports[31:16]) + 20'(ports[15:0])
                   + 20'(seq[31:16]) + 20'(seq[15:0])
                   + 20'(ack[31:16]) + 20'(ack[15:0])
                   + 20'({OFFSET_BYTE, flags});
   endfunction

endpackage

@@ rtl/core/tcphcb_close.sv @@
// ----------------------------------------------------------------------------
// tcphcb_close
// Closes a segment: adds pseudo header and header words, folds, complements
// and assembles the finished 20-byte header.
// ----------------------------------------------------------------------------
module tcphcb_close (
   input  tcphcb_pkg::close_in_type close_in,
   input  logic [31:0]              local_ip,
   input  logic [15:0]              window_size,
   output tcphcb_pkg::result_type   result
);
   import tcphcb_pkg::*;

   logic        over;
   logic [15:0] len;
   logic [20:0] total;
   logic [16:0] fold1;
   logic [15:0] fold2;

   always_comb begin
      over  = close_in.count > MAX_PAYLOAD;
      len   = over ? WORD_MASK : 16'(HDR_BYTES + close_in.count);
      total = 21'(close_in.run_sum) + 21'(close_in.extra) + 21'(close_in.hdr_sum)
            + 21'(local_ip[31:16]) + 21'(local_ip[15:0]) + 21'(PROTO_TCP)
            + 21'(len) + 21'(window_size);
      fold1 = 17'(total[15:0]) + 17'(total[20:16]);
      fold2 = fold1[15:0] + 16'(fold1[16]);

      result.header_front  = {close_in.ports, close_in.seq};
      result.header_middle = {close_in.ack, OFFSET_BYTE, close_in.flags, window_size};
      result.header_back   = {~fold2, 16'h0000};
      result.tcp_length    = len;
      result.status        = over;
   end

endmodule

@@ rtl/core/tcp_header_checksum_builder_core.sv @@
// ----------------------------------------------------------------------------
// tcp_header_checksum_builder_core
// Builds a TCP header with IPv4 pseudo-header checksum over a byte stream.
//
//   channel   dir   handshake              payload
//   req_*     in    req_valid / req_stall  command, header fields, data_byte, last
//   rsp_*     out   rsp_valid / rsp_stall  header_front/middle/back, tcp_length, status
//   csr_*     in    csr_valid / csr_ready  csr_index, csr_data
//
// One item per cycle while req_stall is low: input register, one pass of sum logic, result register.
// The result register loads when the closing item leaves the input register.
// req_stall rises only when a closing item waits on a stalled result register.
// Synchronous reset; no clearing pass. csr_ready is always high.
// ----------------------------------------------------------------------------
module tcp_header_checksum_builder_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_dest_ip,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic [31:0] req_seq_number,
   input  logic [31:0] req_ack_number,
   input  logic [7:0]  req_tcp_flags,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_header_front,
   output logic [63:0] rsp_header_middle,
   output logic [31:0] rsp_header_back,
   output logic [15:0] rsp_tcp_length,
   output logic        rsp_status,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import tcphcb_pkg::*;

   // configuration
   logic [31:0] local_ip_ff, local_ip_in;
   logic [15:0] window_ff, window_in;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic        in_cmd_ff;
   logic        in_last_ff;
   logic [7:0]  in_byte_ff;
   logic [31:0] in_ports_ff;
   logic [31:0] in_seq_ff;
   logic [31:0] in_ack_ff;
   logic [7:0]  in_flags_ff;
   logic [19:0] in_hsum_ff;

   // segment state
   logic        seg_open_ff, seg_open_in;
   logic        odd_ff, odd_in;
   logic [7:0]  held_ff, held_in;
   logic [16:0] run_ff, run_in;
   logic [16:0] count_ff, count_in;
   logic [31:0] lat_ports_ff, lat_ports_in;
   logic [31:0] lat_seq_ff, lat_seq_in;
   logic [31:0] lat_ack_ff, lat_ack_in;
   logic [7:0]  lat_flags_ff, lat_flags_in;
   logic [19:0] lat_hsum_ff, lat_hsum_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;

   logic         req_take;
   logic         is_hdr;
   logic         take;
   logic         closes;
   logic         out_free;
   logic         advance;
   logic         commit;
   logic         base_odd;
   logic [16:0]  base_run;
   logic [16:0]  base_count;
   logic [16:0]  pair_sum;
   close_in_type close_in;
   result_type   close_res;

   assign csr_ready = 1'b1;

   always_comb begin
      local_ip_in = local_ip_ff;
      window_in   = window_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LOCAL_IP:    local_ip_in = csr_data;
            CSR_WINDOW_SIZE: window_in   = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      is_hdr   = in_cmd_ff == CMD_HEADER;
      take     = in_valid_ff && (is_hdr || seg_open_ff);
      closes   = take && in_last_ff;
      out_free = !out_valid_ff || !rsp_stall;
      advance  = in_valid_ff && (!closes || out_free);
      commit   = advance && take;

      req_stall   = in_valid_ff && !advance;
      req_take    = req_valid && !req_stall;
      in_valid_in = req_take || (in_valid_ff && !advance);

      base_run   = is_hdr ? 17'd0 : run_ff;
      base_odd   = is_hdr ? 1'b0 : odd_ff;
      base_count = is_hdr ? 17'd0 : count_ff;

      pair_sum = 17'(run_ff[15:0]) + 17'(run_ff[16]) + 17'({held_ff, in_byte_ff});

      lat_ports_in = is_hdr ? in_ports_ff : lat_ports_ff;
      lat_seq_in   = is_hdr ? in_seq_ff   : lat_seq_ff;
      lat_ack_in   = is_hdr ? in_ack_ff   : lat_ack_ff;
      lat_flags_in = is_hdr ? in_flags_ff : lat_flags_ff;
      lat_hsum_in  = is_hdr ? in_hsum_ff  : lat_hsum_ff;

      run_in   = base_run;
      odd_in   = base_odd;
      held_in  = held_ff;
      count_in = base_count;
      close_in.extra = 16'h0000;
      if (!is_hdr) begin
         if (base_odd) begin
            run_in         = 17'(pair_sum[15:0]) + 17'(pair_sum[16]);
            odd_in         = 1'b0;
            close_in.extra = {held_ff, in_byte_ff};
         end else begin
            held_in        = in_byte_ff;
            odd_in         = 1'b1;
            close_in.extra = {in_byte_ff, 8'h00};
         end
         if (base_count <= MAX_PAYLOAD) begin
            count_in = base_count + 17'd1;
         end
      end
      seg_open_in = !in_last_ff;

      close_in.run_sum = base_run;
      close_in.hdr_sum = lat_hsum_in;
      close_in.ports   = lat_ports_in;
      close_in.seq     = lat_seq_in;
      close_in.ack     = lat_ack_in;
      close_in.flags   = lat_flags_in;
      close_in.count   = count_in;

      if (advance && closes) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   tcphcb_close u_close (
      .close_in    (close_in),
      .local_ip    (local_ip_ff),
      .window_size (window_ff),
      .result      (close_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff  <= 32'd0;
         window_ff    <= WINDOW_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         seg_open_ff  <= 1'b0;
         odd_ff       <= 1'b0;
         run_ff       <= 17'd0;
         count_ff     <= 17'd0;
      end else begin
         local_ip_ff  <= local_ip_in;
         window_ff    <= window_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (commit) begin
            seg_open_ff <= seg_open_in;
            odd_ff      <= odd_in;
            run_ff      <= run_in;
            count_ff    <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff   <= req_command;
         in_last_ff  <= req_last;
         in_byte_ff  <= req_data_byte;
         in_ports_ff <= {req_source_port, req_dest_port};
         in_seq_ff   <= req_seq_number;
         in_ack_ff   <= req_ack_number;
         in_flags_ff <= req_tcp_flags;
         in_hsum_ff  <= hdr_word_sum(req_dest_ip, {req_source_port, req_dest_port},
                                     req_seq_number, req_ack_number, req_tcp_flags);
      end
      if (commit) begin
         held_ff      <= held_in;
         lat_ports_ff <= lat_ports_in;
         lat_seq_ff   <= lat_seq_in;
         lat_ack_ff   <= lat_ack_in;
         lat_flags_ff <= lat_flags_in;
         lat_hsum_ff  <= lat_hsum_in;
      end
      if (advance && closes) begin
         out_ff <= close_res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_header_front  = out_ff.header_front;
   assign rsp_header_middle = out_ff.header_middle;
   assign rsp_header_back   = out_ff.header_back;
   assign rsp_tcp_length    = out_ff.tcp_length;
   assign rsp_status        = out_ff.status;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_PAYLOAD + 17'd1)
      else $error("payload count beyond saturation");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff <= 17'h10000)
      else $error("running sum not folded");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && rsp_stall && in_valid_ff))
      else $error("input stalled without a blocked result");

   a_over_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_tcp_length == WORD_MASK))
      else $error("overflow result with short length");

   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_status) |-> (rsp_tcp_length >= 16'(HDR_BYTES)))
      else $error("result length below header size");

endmodule

@@ tb/sv/tb_tcp_header_checksum_builder_core.sv @@
// ----------------------------------------------------------------------------
// tb_tcp_header_checksum_builder_core
// Self-checking bench for the TCP header checksum builder. Header and payload
// items go in from a queue through a driver with random gaps. A predictor
// keeps its own segment state and computes the pseudo-header checksum at
// each closing item. A monitor compares every result with the oldest
// predicted header while the receiver stalls at random. Runs cover reset
// and extreme register values, a long receiver hold-off, a stretch with
// no idling, and several random traffic phases.
// ----------------------------------------------------------------------------
module tb_tcp_header_checksum_builder_core;
   timeunit 1ns;
   timeprecision 1ps;

   import tcphcb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned HOLD_CYCLES = 400;

   typedef struct packed {
      logic        command;
      logic [31:0] dest_ip;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [31:0] seq_number;
      logic [31:0] ack_number;
      logic [7:0]  tcp_flags;
      logic [7:0]  data_byte;
      logic        last;
   } seg_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command;
   logic [31:0] req_dest_ip;
   logic [15:0] req_source_port;
   logic [15:0] req_dest_port;
   logic [31:0] req_seq_number;
   logic [31:0] req_ack_number;
   logic [7:0]  req_tcp_flags;
   logic [7:0]  req_data_byte;
   logic        req_last;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_header_front;
   logic [63:0] rsp_header_middle;
   logic [31:0] rsp_header_back;
   logic [15:0] rsp_tcp_length;
   logic        rsp_status;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_LOCAL_IP;
   logic [31:0] csr_data = '0;

   seg_item_type req_cur = '0;
   seg_item_type item_queue[$];
   result_type   header_queue[$];

   logic        req_fire = 1'b0;
   int unsigned idle_pct = 34;
   logic        hold_armed = 1'b0;
   int unsigned hold_count = 0;
   int unsigned err_count = 0;
   int unsigned cycle_count = 0;

   // predictor state
   logic [31:0] cfg_local_ip = '0;
   logic [15:0] cfg_window = WINDOW_RESET;
   logic [31:0] seg_sum = '0;
   logic [16:0] seg_count = '0;
   logic [7:0]  seg_high = '0;
   logic        seg_odd = 1'b0;
   logic        seg_open = 1'b0;
   logic [31:0] seg_dest_ip = '0;
   logic [31:0] seg_ports = '0;
   logic [31:0] seg_seq = '0;
   logic [31:0] seg_ack = '0;
   logic [7:0]  seg_flags = '0;

   assign req_command     = req_cur.command;
   assign req_dest_ip     = req_cur.dest_ip;
   assign req_source_port = req_cur.source_port;
   assign req_dest_port   = req_cur.dest_port;
   assign req_seq_number  = req_cur.seq_number;
   assign req_ack_number  = req_cur.ack_number;
   assign req_tcp_flags   = req_cur.tcp_flags;
   assign req_data_byte   = req_cur.data_byte;
   assign req_last        = req_cur.last;

   tcp_header_checksum_builder_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_dest_ip       (req_dest_ip),
      .req_source_port   (req_source_port),
      .req_dest_port     (req_dest_port),
      .req_seq_number    (req_seq_number),
      .req_ack_number    (req_ack_number),
      .req_tcp_flags     (req_tcp_flags),
      .req_data_byte     (req_data_byte),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_header_front  (rsp_header_front),
      .rsp_header_middle (rsp_header_middle),
      .rsp_header_back   (rsp_header_back),
      .rsp_tcp_length    (rsp_tcp_length),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] ones_add(input logic [31:0] acc, input logic [15:0] word);
      logic [31:0] s;
      s = acc + 32'(word);
      return {16'h0, s[15:0]} + (s >> 16);
   endfunction

   function automatic void predict_item(input seg_item_type it);
      result_type  r;
      logic [31:0] s;
      logic        over;
      logic [15:0] len;
      logic [15:0] mid;
      if (it.command == CMD_HEADER) begin
         seg_dest_ip = it.dest_ip;
         seg_ports   = {it.source_port, it.dest_port};
         seg_seq     = it.seq_number;
         seg_ack     = it.ack_number;
         seg_flags   = it.tcp_flags;
         seg_sum     = '0;
         seg_count   = '0;
         seg_high    = '0;
         seg_odd     = 1'b0;
         seg_open    = 1'b1;
      end else begin
         if (!seg_open) return;
         if (seg_odd) begin
            seg_sum = ones_add(seg_sum, {seg_high, it.data_byte});
            seg_odd = 1'b0;
         end else begin
            seg_high = it.data_byte;
            seg_odd  = 1'b1;
         end
         if (seg_count <= MAX_PAYLOAD) seg_count++;
      end
      if (!it.last) return;
      over = seg_count > MAX_PAYLOAD;
      len  = over ? WORD_MASK : 16'(HDR_BYTES + seg_count);
      mid  = {OFFSET_BYTE, seg_flags};
      s    = seg_sum;
      if (seg_odd) s = ones_add(s, {seg_high, 8'h00});
      s = ones_add(s, cfg_local_ip[31:16]);
      s = ones_add(s, cfg_local_ip[15:0]);
      s = ones_add(s, seg_dest_ip[31:16]);
      s = ones_add(s, seg_dest_ip[15:0]);
      s = ones_add(s, PROTO_TCP);
      s = ones_add(s, len);
      s = ones_add(s, seg_ports[31:16]);
      s = ones_add(s, seg_ports[15:0]);
      s = ones_add(s, seg_seq[31:16]);
      s = ones_add(s, seg_seq[15:0]);
      s = ones_add(s, seg_ack[31:16]);
      s = ones_add(s, seg_ack[15:0]);
      s = ones_add(s, mid);
      s = ones_add(s, cfg_window);
      s = {16'h0, s[15:0]} + (s >> 16);
      r.header_front  = {seg_ports, seg_seq};
      r.header_middle = {seg_ack, mid, cfg_window};
      r.header_back   = {~s[15:0], 16'h0000};
      r.tcp_length    = len;
      r.status        = over;
      header_queue.push_back(r);
      seg_open = 1'b0;
   endfunction

   // ---------------- stimulus builders ----------------
   function automatic seg_item_type random_item(input logic cmd, input logic lst);
      seg_item_type it;
      it.command     = cmd;
      it.dest_ip     = $urandom;
      it.source_port = 16'($urandom);
      it.dest_port   = 16'($urandom);
      it.seq_number  = $urandom;
      it.ack_number  = $urandom;
      it.tcp_flags   = 8'($urandom);
      it.data_byte   = 8'($urandom);
      it.last        = lst;
      return it;
   endfunction

   function automatic seg_item_type filled_header(input logic fill, input logic lst);
      seg_item_type it;
      it             = random_item(CMD_HEADER, lst);
      it.dest_ip     = {32{fill}};
      it.source_port = {16{fill}};
      it.dest_port   = {16{fill}};
      it.seq_number  = {32{fill}};
      it.ack_number  = {32{fill}};
      it.tcp_flags   = {8{fill}};
      return it;
   endfunction

   function automatic seg_item_type byte_item(input logic [7:0] b, input logic lst);
      seg_item_type it;
      it           = random_item(CMD_PAYLOAD, lst);
      it.data_byte = b;
      return it;
   endfunction

   function automatic void add_segment(input int unsigned nbytes);
      item_queue.push_back(random_item(CMD_HEADER, nbytes == 0));
      for (int unsigned i = 0; i < nbytes; i++)
         item_queue.push_back(byte_item(8'($urandom), i == nbytes - 1));
   endfunction

   function automatic void add_random_traffic(input int unsigned n_items);
      int unsigned start;
      int unsigned pick;
      start = item_queue.size();
      while (item_queue.size() - start < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 56)
            add_segment($urandom_range(0, 8));
         else if (pick < 76)
            add_segment($urandom_range(9, 64));
         else if (pick < 80)
            add_segment($urandom_range(65, 300));
         else if (pick < 90) begin
            // segment left open, the next header restarts it
            item_queue.push_back(random_item(CMD_HEADER, 1'b0));
            repeat ($urandom_range(0, 5)) item_queue.push_back(byte_item(8'($urandom), 1'b0));
         end else begin
            repeat ($urandom_range(1, 3))
               item_queue.push_back(random_item(CMD_PAYLOAD, 1'($urandom_range(0, 1))));
         end
      end
   endfunction

   task automatic csr_write(input logic idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_WINDOW_SIZE) cfg_window = value[15:0];
      else cfg_local_ip = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_all();
      do @(negedge clock);
      while (item_queue.size() != 0 || req_valid || header_queue.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_item(req_cur);
         req_fire = 1'b1;
      end else begin
         req_fire = 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_fire || !req_valid) begin
         if (item_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_cur   <= item_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- receiver ----------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_armed && hold_count < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         hold_count++;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < idle_pct);
      end
   end

   // ---------------- monitor ----------------
   function automatic void field_check(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         err_count++;
         if (err_count <= 10)
            $display("mismatch %s: expected %h actual %h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : rsp_monitor
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (header_queue.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("unexpected result: front %h middle %h",
                        rsp_header_front, rsp_header_middle);
         end else begin
            want = header_queue.pop_front();
            field_check("header_front", want.header_front, rsp_header_front);
            field_check("header_middle", want.header_middle, rsp_header_middle);
            field_check("header_back", 64'(want.header_back), 64'(rsp_header_back));
            field_check("tcp_length", 64'(want.tcp_length), 64'(rsp_tcp_length));
            field_check("status", 64'(want.status), 64'(rsp_status));
         end
      end
   end

   // ---------------- timeout ----------------
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_tcp_header_checksum_builder_core failed");
      $finish;
   end

   // ---------------- sequence ----------------
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset register values, directed corners
      item_queue.push_back(filled_header(1'b0, 1'b1));
      item_queue.push_back(filled_header(1'b1, 1'b1));
      item_queue.push_back(byte_item(8'hFF, 1'b1));
      item_queue.push_back(byte_item(8'h00, 1'b0));
      item_queue.push_back(random_item(CMD_HEADER, 1'b0));
      item_queue.push_back(byte_item(8'hFF, 1'b1));
      item_queue.push_back(random_item(CMD_HEADER, 1'b0));
      item_queue.push_back(byte_item(8'h00, 1'b0));
      item_queue.push_back(byte_item(8'hFF, 1'b1));
      item_queue.push_back(random_item(CMD_HEADER, 1'b0));
      item_queue.push_back(byte_item(8'hAB, 1'b0));
      item_queue.push_back(filled_header(1'b1, 1'b0));
      item_queue.push_back(byte_item(8'hFF, 1'b0));
      item_queue.push_back(byte_item(8'hFF, 1'b0));
      item_queue.push_back(byte_item(8'hFF, 1'b1));
      item_queue.push_back(filled_header(1'b0, 1'b0));
      item_queue.push_back(byte_item(8'h80, 1'b0));
      item_queue.push_back(byte_item(8'h01, 1'b1));
      drain_all();

      csr_write(CSR_LOCAL_IP, 32'hFFFF_FFFF);
      csr_write(CSR_WINDOW_SIZE, 32'h0000_FFFF);
      item_queue.push_back(filled_header(1'b1, 1'b1));
      item_queue.push_back(filled_header(1'b0, 1'b0));
      item_queue.push_back(byte_item(8'hFF, 1'b0));
      item_queue.push_back(byte_item(8'hFF, 1'b1));
      drain_all();

      csr_write(CSR_LOCAL_IP, 32'h0);
      csr_write(CSR_WINDOW_SIZE, 32'h0);
      item_queue.push_back(filled_header(1'b0, 1'b1));
      item_queue.push_back(filled_header(1'b1, 1'b0));
      item_queue.push_back(byte_item(8'h55, 1'b1));
      drain_all();

      // no idling on either side
      idle_pct = 0;
      csr_write(CSR_LOCAL_IP, $urandom);
      csr_write(CSR_WINDOW_SIZE, $urandom_range(0, 65535));
      add_segment(3);
      add_segment(0);
      add_random_traffic(120);
      drain_all();
      idle_pct = 34;

      csr_write(CSR_LOCAL_IP, $urandom);
      csr_write(CSR_WINDOW_SIZE, $urandom_range(0, 65535));
      add_random_traffic(200);
      drain_all();

      // long receiver hold-off while short segments keep coming
      csr_write(CSR_LOCAL_IP, $urandom);
      csr_write(CSR_WINDOW_SIZE, $urandom_range(0, 65535));
      hold_armed = 1'b1;
      repeat (60) add_segment($urandom_range(0, 3));
      drain_all();

      csr_write(CSR_LOCAL_IP, $urandom);
      csr_write(CSR_WINDOW_SIZE, $urandom_range(0, 65535));
      add_random_traffic(250);
      drain_all();

      if (err_count == 0)
         $display("tb_tcp_header_checksum_builder_core passed");
      else
         $display("tb_tcp_header_checksum_builder_core failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/tcphcb_pkg.sv
rtl/core/tcphcb_close.sv
rtl/core/tcp_header_checksum_builder_core.sv
tb/sv/tb_tcp_header_checksum_builder_core.sv
